// ----- rtl/core/tccw_pkg.sv -----
// Shared types and constants for the text console cell writer.
// No dependencies; imported by every module of the block.
package tccw_pkg;

  localparam int CELL_AW = 12;   // covers the largest screen, 128 x 32 cells
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int OFF_W   = 11;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SETXY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7F;

  localparam logic [15:0] RESET_BLANK = 16'h0F20;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       char_code;
    logic [COL_W-1:0] pos_x;
    logic [ROW_W-1:0] pos_y;
    logic [10:0]      cell_index;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] cursor_offset;
    logic [15:0]      cell_word;
    logic             scrolled;
  } out_item_t;

  // One classified item on its way to the memory engine.
  typedef struct packed {
    logic               wr;
    logic               scr;
    logic               clr;
    logic               rd;
    logic [CELL_AW-1:0] addr;
    logic [15:0]        char_word;
    logic [15:0]        blank;
    logic [OFF_W-1:0]   off;
  } op_t;

endpackage

// ----- rtl/core/tccw_front.sv -----
// Front end: cursor tracking and command decode into memory operations.
// Depends on tccw_pkg.
module tccw_front import tccw_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  input  logic [3:0] fg,
  input  logic [3:0] bg,
  output op_t      op
);

  localparam int NSTOP = COLUMNS / TAB_STOP + 1;
  localparam int NCELL = COLUMNS * ROWS;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       c_n;
  logic [5:0]       r_n;
  logic [7:0]       tab_c;
  logic [15:0]      attr_hi;

  always_comb begin
    tab_c = 8'(COLUMNS + TAB_STOP);
    for (int k = NSTOP; k >= 1; k--) begin
      if (8'(k * TAB_STOP) > {1'b0, col_r}) tab_c = 8'(k * TAB_STOP);
    end
  end

  assign attr_hi = {bg, fg, 8'h00};

  always_comb begin
    op       = '0;
    op.blank = attr_hi | {8'h00, CH_SPACE};
    c_n      = {1'b0, col_r};
    r_n      = {1'b0, row_r};
    unique case (in_item.cmd)
      CMD_PUT: begin
        op.addr      = CELL_AW'(row_r) * CELL_AW'(COLUMNS) + CELL_AW'(col_r);
        op.char_word = attr_hi | {8'h00, in_item.char_code};
        priority if (in_item.char_code == CH_BS) begin
          if (col_r != '0) c_n = {1'b0, col_r} - 8'd1;
        end else if (in_item.char_code == CH_TAB) begin
          c_n = tab_c;
        end else if (in_item.char_code == CH_CR) begin
          c_n = '0;
        end else if (in_item.char_code == CH_LF) begin
          c_n = '0;
          r_n = r_n + 6'd1;
        end else if (in_item.char_code >= CH_SPACE && in_item.char_code <= CH_LAST) begin
          op.wr = 1'b1;
          c_n   = c_n + 8'd1;
        end else begin
          c_n = {1'b0, col_r};
        end
        if (c_n >= 8'(COLUMNS)) begin
          c_n = '0;
          r_n = r_n + 6'd1;
        end
      end
      CMD_SETXY: begin
        c_n = ({1'b0, in_item.pos_x} > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1)
                                                         : {1'b0, in_item.pos_x};
        r_n = {1'b0, in_item.pos_y};
      end
      CMD_CLEAR: begin
        op.clr = 1'b1;
        c_n    = '0;
        r_n    = '0;
      end
      default: begin
        op.addr = CELL_AW'(in_item.cell_index);
        op.rd   = ({2'b00, in_item.cell_index} < 13'(NCELL));
      end
    endcase
    if (r_n >= 6'(ROWS)) begin
      op.scr = 1'b1;
      r_n    = 6'(ROWS - 1);
    end
    col_nxt = c_n[COL_W-1:0];
    row_nxt = r_n[ROW_W-1:0];
    op.off  = OFF_W'(CELL_AW'(row_nxt) * CELL_AW'(COLUMNS) + CELL_AW'(col_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- rtl/core/tccw_queue.sv -----
// Two-entry queue of decoded operations between front end and engine.
// Depends on tccw_pkg.
module tccw_queue import tccw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  op_t  wr_op,
  output logic full,
  input  logic rd_en,
  output op_t  rd_op,
  output logic valid
);

  op_t        mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rd_op = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ----- rtl/core/tccw_back.sv -----
// Back end: screen memory engine (write, read, scroll, clear) and result register.
// Depends on tccw_pkg.
module tccw_back import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  output logic      init_busy,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  localparam int NCELL = COLUMNS * ROWS;
  localparam int AW    = $clog2(NCELL);
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(NCELL - 1);
  localparam logic [CELL_AW-1:0] LAST_COPY = CELL_AW'(NCELL - COLUMNS - 1);
  localparam logic [CELL_AW-1:0] BOT_ROW   = CELL_AW'(NCELL - COLUMNS);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_SCROLL = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_BLANK  = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  op_t                op_r;
  logic               init_r;
  logic               cp_v_r;
  logic [CELL_AW-1:0] cp_a_r;
  logic               ov_r;
  out_item_t          out_r, out_nxt;
  logic               out_set, imm, done_blank, done_clear;

  logic [15:0]        mem [NCELL];
  logic [15:0]        rd_q;
  logic               we;
  logic [CELL_AW-1:0] wa, ra;
  logic [15:0]        wd;
  logic               can_out, take;

  assign can_out   = !ov_r || pop;
  assign take      = (state_r == ST_IDLE) && q_valid && can_out;
  assign q_pop     = take;
  assign init_busy = init_r;
  assign empty     = !ov_r;
  assign out_item  = out_r;

  assign imm        = take && !q_op.scr && !q_op.clr && !q_op.rd;
  assign done_blank = (state_r == ST_BLANK) && (cnt_r == LAST_CELL);
  assign done_clear = (state_r == ST_CLEAR) && (cnt_r == LAST_CELL);

  always_comb begin
    we        = 1'b0;
    wa        = cnt_r;
    wd        = op_r.blank;
    ra        = q_op.addr;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          we = q_op.wr;
          wa = q_op.addr;
          wd = q_op.char_word;
          cnt_nxt = '0;
          priority if (q_op.scr) state_nxt = ST_SCROLL;
          else if (q_op.clr)     state_nxt = ST_CLEAR;
          else if (q_op.rd)      state_nxt = ST_READ;
          else                   state_nxt = ST_IDLE;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_SCROLL: begin
        we = cp_v_r;
        wa = cp_a_r;
        wd = rd_q;
        ra = cnt_r + CELL_AW'(COLUMNS);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_COPY) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        we = 1'b1;
        wa = cp_a_r;
        wd = rd_q;
        cnt_nxt   = BOT_ROW;
        state_nxt = ST_BLANK;
      end
      ST_BLANK, ST_CLEAR: begin
        we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // the clearing pass after reset produces no result
  always_comb begin
    out_set = 1'b1;
    out_nxt = out_r;
    priority if (imm) begin
      out_nxt = '{cursor_offset: q_op.off, cell_word: 16'h0000, scrolled: 1'b0};
    end else if (state_r == ST_READ) begin
      out_nxt = '{cursor_offset: op_r.off, cell_word: rd_q, scrolled: 1'b0};
    end else if (done_blank) begin
      out_nxt = '{cursor_offset: op_r.off, cell_word: 16'h0000, scrolled: 1'b1};
    end else if (done_clear && !init_r) begin
      out_nxt = '{cursor_offset: op_r.off, cell_word: 16'h0000, scrolled: 1'b0};
    end else begin
      out_set = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa[AW-1:0]] <= wd;
    rd_q <= mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (out_set) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      init_r   <= 1'b1;
      op_r     <= '{blank: RESET_BLANK, default: '0};
      cp_v_r   <= 1'b0;
      cp_a_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cp_v_r  <= (state_r == ST_SCROLL);
      cp_a_r  <= cnt_r;
      ov_r    <= out_set || (ov_r && !pop);
      if (take) op_r <= q_op;
      if (done_clear) init_r <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/text_console_cell_writer.sv -----
// Top level of the text console cell writer: color registers, front end, queue, engine.
// Depends on tccw_pkg, tccw_front, tccw_queue, tccw_back.
//
// Character, control and set-position commands that need no scroll are finished by
// the memory engine as it takes them; a cell read goes on through ST_READ (registered
// memory read). A scroll copies the screen up one row through the single memory port
// pair and blanks the bottom row; clear screen writes every cell. After reset a
// clearing pass fills the screen with blanks while full stays high. A two-entry queue
// lets new items be taken while the engine works, and one result register holds the
// oldest result.
module text_console_cell_writer import tccw_pkg::*; #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] fg_r, bg_r;
  logic       q_full, q_valid, q_pop, init_busy, accept;
  op_t        f_op, q_op;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BG) ? {28'h0, bg_r} : {28'h0, fg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 4'hF;
      bg_r <= 4'h0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FG) fg_r <= pwdata[3:0];
      else                    bg_r <= pwdata[3:0];
    end
  end

  assign full   = q_full || init_busy;
  assign accept = push && !full;

  tccw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)) u_front (
    .clk, .rst_n, .accept, .in_item, .fg(fg_r), .bg(bg_r), .op(f_op)
  );

  tccw_queue u_queue (
    .clk, .rst_n, .wr_en(accept), .wr_op(f_op), .full(q_full),
    .rd_en(q_pop), .rd_op(q_op), .valid(q_valid)
  );

  tccw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk, .rst_n, .q_valid, .q_op, .q_pop, .init_busy,
    .out_item, .empty, .pop
  );

endmodule

// ----- bench/tb_text_console_cell_writer.sv -----
// Self-checking bench for the text console cell writer: directed and random command
// streams, a model of the cell store and cursor, color register writes over APB.
// Depends on tccw_pkg and text_console_cell_writer.
module tb_text_console_cell_writer import tccw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOL  = 80;
  localparam int NROW  = 25;
  localparam int NCELL = NCOL * NROW;
  localparam int TABW  = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int IN_W  = $bits(in_item_t);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_cell_writer dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // screen model
  logic [15:0] cells [NCELL];
  int unsigned col, row;
  logic [3:0]  fg, bg;
  out_item_t   pending_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          out_quiet = 1'b0;

  function automatic logic [15:0] blank_word();
    return {bg, fg, CH_SPACE};
  endfunction

  function automatic bit scroll_if_low();
    if (row < NROW) return 1'b0;
    for (int i = 0; i < NCELL - NCOL; i++) cells[i] = cells[i + NCOL];
    for (int i = NCELL - NCOL; i < NCELL; i++) cells[i] = blank_word();
    row = NROW - 1;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_cursor(in_item_t it);
    out_item_t r;
    r = '0;
    case (cmd_t'(it.cmd))
      CMD_PUT: begin
        if (it.char_code == CH_BS) begin
          if (col != 0) col--;
        end else if (it.char_code == CH_TAB) begin
          col = col + TABW - (col % TABW);
        end else if (it.char_code == CH_CR) begin
          col = 0;
        end else if (it.char_code == CH_LF) begin
          col = 0;
          row++;
        end else if (it.char_code >= CH_SPACE && it.char_code <= CH_LAST) begin
          if (row * NCOL + col < NCELL) cells[row * NCOL + col] = {bg, fg, it.char_code};
          col++;
        end
        if (col >= NCOL) begin
          col = 0;
          row++;
        end
        r.scrolled = scroll_if_low();
      end
      CMD_SETXY: begin
        col = (it.pos_x > NCOL - 1) ? NCOL - 1 : it.pos_x;
        row = it.pos_y;
        r.scrolled = scroll_if_low();
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NCELL; i++) cells[i] = blank_word();
        col = 0;
        row = 0;
      end
      default: begin
        if (it.cell_index < NCELL) r.cell_word = cells[it.cell_index];
      end
    endcase
    r.cursor_offset = OFF_W'(row * NCOL + col);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // gap before a beat: mostly none or short, sometimes long
  task automatic random_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) return;
    if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // push stays high after the beat; the next gap or idle point drops it
  task automatic send_item(in_item_t it, bit gaps = 1'b1);
    if (gaps) random_gap();
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_q.push_back(predict_cursor(it));
  endtask

  task automatic write_reg(logic reg_sel, logic [3:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00}; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_sel == REG_FG) fg = v;
    else bg = v;
  endtask

  // idle point: all results back, then let a scroll or clear in flight drain
  task automatic drain();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
  endtask

  function automatic in_item_t mk(cmd_t c, int ch = 0, int x = 0, int y = 0, int ci = 0);
    in_item_t it;
    it.cmd = c;
    it.char_code = 8'(ch);
    it.pos_x = COL_W'(x);
    it.pos_y = ROW_W'(y);
    it.cell_index = 11'(ci);
    return it;
  endfunction

  // result checker with random pop stalls
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected beat", int'(out_item), 0);
      end else begin
        out_item_t w;
        w = pending_q.pop_front();
        if (out_item.cursor_offset !== w.cursor_offset)
          report_mismatch("cursor_offset", int'(out_item.cursor_offset),
                          int'(w.cursor_offset));
        if (out_item.cell_word !== w.cell_word)
          report_mismatch("cell_word", int'(out_item.cell_word), int'(w.cell_word));
        if (out_item.scrolled !== w.scrolled)
          report_mismatch("scrolled", int'(out_item.scrolled), int'(w.scrolled));
      end
    end
    if (hold_off) pop <= 1'b0;
    else if (out_quiet) pop <= 1'b1;
    else pop <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_cell_writer test failed");
      $finish;
    end
  end

  task automatic test_controls();
    send_item(mk(CMD_PUT, 8'h08));          // backspace at column zero
    send_item(mk(CMD_PUT, 8'h41));
    send_item(mk(CMD_PUT, 8'h7F));
    send_item(mk(CMD_PUT, 8'h08));
    send_item(mk(CMD_PUT, 8'h09));
    send_item(mk(CMD_PUT, 8'h0D));
    send_item(mk(CMD_PUT, 8'h0A));
    send_item(mk(CMD_PUT, 8'h00));
    send_item(mk(CMD_PUT, 8'hFF));
    send_item(mk(CMD_PUT, 8'h80));
    send_item(mk(CMD_PUT, 8'h20));
    send_item(mk(CMD_READ, 0, 0, 0, 0));
    send_item(mk(CMD_READ, 0, 0, 0, 1));
    send_item(mk(CMD_READ, 0, 0, 0, 2047)); // out of range
    send_item(mk(CMD_READ, 0, 0, 0, 1999));
  endtask

  task automatic test_position();
    send_item(mk(CMD_SETXY, 0, 127, 0));
    send_item(mk(CMD_PUT, 8'h5A));          // wraps from last column
    send_item(mk(CMD_SETXY, 0, 79, 24));
    send_item(mk(CMD_PUT, 8'h09));          // tab off the last line scrolls
    send_item(mk(CMD_SETXY, 0, 5, 31));
    send_item(mk(CMD_PUT, 8'h0A));
    send_item(mk(CMD_READ, 0, 0, 0, 1920));
    send_item(mk(CMD_CLEAR));
    send_item(mk(CMD_READ, 0, 0, 0, 0));
  endtask

  task automatic test_colors();
    logic [3:0] pairs [4][2] = '{'{4'h0, 4'h0}, '{4'hF, 4'hF}, '{4'hA, 4'h5}, '{4'h5, 4'hA}};
    foreach (pairs[p]) begin
      drain();
      write_reg(REG_FG, pairs[p][0]);
      write_reg(REG_BG, pairs[p][1]);
      send_item(mk(CMD_PUT, 8'h61));
      send_item(mk(CMD_SETXY, 0, 0, 25));
      send_item(mk(CMD_READ, 0, 0, 0, 1920));
      send_item(mk(CMD_READ, 0, 0, 0, 1919));
    end
  endtask

  task automatic test_random(int count);
    in_item_t it;
    int k;
    for (int i = 0; i < count; i++) begin
      it = in_item_t'(IN_W'({$urandom, $urandom}));
      k = $urandom_range(0, 99);
      if (k < 55) begin
        it.cmd = CMD_PUT;
        if (k < 40) it.char_code = 8'($urandom_range(8'h20, 8'h7E));
        else if (k < 50) it.char_code = 8'($urandom_range(8, 13));
      end else if (k < 68) begin
        it.cmd = CMD_SETXY;
        if (k < 66) it.pos_y = ROW_W'($urandom_range(0, 24));
      end else if (k < 69) begin
        it.cmd = CMD_CLEAR;
      end else begin
        it.cmd = CMD_READ;
        if (k < 95) it.cell_index = 11'($urandom_range(0, NCELL - 1));
      end
      send_item(it);
      if (i % 300 == 299) begin
        drain();
        write_reg(REG_FG, 4'($urandom));
        write_reg(REG_BG, 4'($urandom));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so full must assert
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_item(mk(CMD_PUT, 8'h30 + i), 1'b0);
    join
    out_quiet = 1'b1;
    for (int i = 0; i < 40; i++) send_item(mk(CMD_READ, 0, 0, 0, i), 1'b0);
    out_quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NCELL; i++) cells[i] = RESET_BLANK;
    col = 0; row = 0; fg = 4'hF; bg = 4'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_controls();
    test_position();
    test_colors();
    test_backpressure();
    test_random(1000);
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("text_console_cell_writer test passed");
    else $display("text_console_cell_writer test failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/tccw_pkg.sv
rtl/core/tccw_front.sv
rtl/core/tccw_queue.sv
rtl/core/tccw_back.sv
rtl/core/text_console_cell_writer.sv
bench/tb_text_console_cell_writer.sv
